// ----- design/gzhp_pkg.sv -----
// gzip header parser package: item types, section codes and parser state
// no dependencies
package gzhp_pkg;

    localparam int unsigned FIXED_BYTES = 10;
    localparam int unsigned EXTRA_BYTES = 4;
    localparam int unsigned FLAG_EXTRA_BIT = 2;
    localparam int unsigned FLAG_NAME_BIT = 3;

    // section tags; also used as the parser phase
    typedef enum logic [2:0] {
        SEC_FIXED = 3'd0,
        SEC_XHDR  = 3'd1,
        SEC_XSKIP = 3'd2,
        SEC_NAME  = 3'd3,
        SEC_TERM  = 3'd4,
        SEC_PAST  = 3'd5
    } sec_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_member;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  section;
        logic [15:0] id_word;
        logic [7:0]  method;
        logic [7:0]  flags;
        logic [31:0] mod_time;
        logic [7:0]  extra_flags;
        logic [7:0]  os_code;
        logic [15:0] subfield_id;
        logic [15:0] extra_length;
        logic        header_done;
    } out_t;

    typedef struct packed {
        sec_t                              phase;
        logic [3:0]                        byte_index;
        logic [FIXED_BYTES-1:0][7:0]       hdr;
        logic [EXTRA_BYTES-1:0][7:0]       ext;
        logic [15:0]                       skip;
    } state_t;

endpackage

// ----- design/gzhp_step.sv -----
// gzip header parser step logic: next parser state and result for one byte
// depends on gzhp_pkg
module gzhp_step (
    input  gzhp_pkg::state_t st,
    input  gzhp_pkg::in_t    din,
    output gzhp_pkg::state_t st_next,
    output gzhp_pkg::out_t   res
);

    gzhp_pkg::state_t base;
    gzhp_pkg::sec_t   sec;
    logic             done;
    logic [7:0]       b;
    logic [15:0]      len_new;
    logic             name_flag;

    assign b = din.in_byte;
    assign len_new = {b, base.ext[2]};
    assign name_flag = st_next.hdr[3][gzhp_pkg::FLAG_NAME_BIT];

    // start of member behaves as a reset before this byte
    always_comb begin
        base = st;
        if (din.start_member) begin
            base = '0;
            base.phase = gzhp_pkg::SEC_FIXED;
        end
    end

    // next state
    always_comb begin
        st_next = base;
        case (base.phase)
            gzhp_pkg::SEC_FIXED: begin
                for (int i = 0; i < gzhp_pkg::FIXED_BYTES; i++) begin
                    if (base.byte_index == 4'(i)) begin
                        st_next.hdr[i] = b;
                    end
                end
                if (base.byte_index >= 4'd9) begin
                    st_next.byte_index = '0;
                    if (st_next.hdr[3][gzhp_pkg::FLAG_EXTRA_BIT]) begin
                        st_next.phase = gzhp_pkg::SEC_XHDR;
                    end else if (st_next.hdr[3][gzhp_pkg::FLAG_NAME_BIT]) begin
                        st_next.phase = gzhp_pkg::SEC_NAME;
                    end else begin
                        st_next.phase = gzhp_pkg::SEC_PAST;
                    end
                end else begin
                    st_next.byte_index = base.byte_index + 4'd1;
                end
            end
            gzhp_pkg::SEC_XHDR: begin
                st_next.ext[base.byte_index[1:0]] = b;
                if (base.byte_index >= 4'd3) begin
                    st_next.byte_index = '0;
                    st_next.skip = len_new;
                    if (len_new != 16'd0) begin
                        st_next.phase = gzhp_pkg::SEC_XSKIP;
                    end else if (base.hdr[3][gzhp_pkg::FLAG_NAME_BIT]) begin
                        st_next.phase = gzhp_pkg::SEC_NAME;
                    end else begin
                        st_next.phase = gzhp_pkg::SEC_PAST;
                    end
                end else begin
                    st_next.byte_index = base.byte_index + 4'd1;
                end
            end
            gzhp_pkg::SEC_XSKIP: begin
                if (base.skip != 16'd0) begin
                    st_next.skip = base.skip - 16'd1;
                end
                if (base.skip <= 16'd1) begin
                    if (base.hdr[3][gzhp_pkg::FLAG_NAME_BIT]) begin
                        st_next.phase = gzhp_pkg::SEC_NAME;
                    end else begin
                        st_next.phase = gzhp_pkg::SEC_PAST;
                    end
                end
            end
            gzhp_pkg::SEC_NAME: begin
                if (b == 8'd0) begin
                    st_next.phase = gzhp_pkg::SEC_PAST;
                end
            end
            default: begin
                st_next.phase = gzhp_pkg::SEC_PAST;
            end
        endcase
    end

    // section tag and header end
    always_comb begin
        sec  = base.phase;
        done = 1'b0;
        case (base.phase)
            gzhp_pkg::SEC_FIXED: begin
                done = (base.byte_index >= 4'd9)
                    && !st_next.hdr[3][gzhp_pkg::FLAG_EXTRA_BIT] && !name_flag;
            end
            gzhp_pkg::SEC_XHDR: begin
                done = (base.byte_index >= 4'd3) && (len_new == 16'd0) && !name_flag;
            end
            gzhp_pkg::SEC_XSKIP: begin
                done = (base.skip <= 16'd1) && !name_flag;
            end
            gzhp_pkg::SEC_NAME: begin
                if (b == 8'd0) begin
                    sec  = gzhp_pkg::SEC_TERM;
                    done = 1'b1;
                end
            end
            default: begin
                sec = gzhp_pkg::SEC_PAST;
            end
        endcase
    end

    always_comb begin
        res.out_byte     = b;
        res.section      = sec;
        res.id_word      = {st_next.hdr[0], st_next.hdr[1]};
        res.method       = st_next.hdr[2];
        res.flags        = st_next.hdr[3];
        res.mod_time     = {st_next.hdr[7], st_next.hdr[6], st_next.hdr[5], st_next.hdr[4]};
        res.extra_flags  = st_next.hdr[8];
        res.os_code      = st_next.hdr[9];
        res.subfield_id  = {st_next.ext[1], st_next.ext[0]};
        res.extra_length = {st_next.ext[3], st_next.ext[2]};
        res.header_done  = done;
    end

endmodule

// ----- design/gzip_header_parser_core.sv -----
// registered: an accepted input item has its result item on m_ from the next cycle
// throughput: one byte item per cycle; the output register is refilled in
// the same cycle it is drained, so only a stalled m_ready holds s_ready low
// reset (aresetn low, synchronous): parser goes to the fixed header section
// with all captures zero and the output register empty
// depends on gzhp_pkg and gzhp_step
module gzip_header_parser_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gzhp_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gzhp_pkg::out_t   m_data
);

    // parser state: phase, byte counter, capture registers, skip count
    gzhp_pkg::state_t state_reg;
    gzhp_pkg::state_t state_next;

    // result register and its valid flag
    gzhp_pkg::out_t   out_reg;
    gzhp_pkg::out_t   out_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    logic             in_fire;

    // one byte of parsing: all combinational, state in, state and result out
    gzhp_step u_step (
        .st      (state_reg),
        .din     (s_data),
        .st_next (state_next),
        .res     (out_next)
    );

    // take a new item whenever the result slot is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // parser state only moves on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // all zero: phase code zero is the fixed header section
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
